// File: sv/flsc_pkg.sv
// Shared types and constants of the frequency load shedding controller.
package flsc_pkg;

  localparam int FREQ_W  = 22;
  localparam int SUM_W   = 23;
  localparam int DVD_W   = 67;
  localparam int DVS_W   = 32;
  localparam int MULA_W  = 44;
  localparam int MULB_W  = 22;
  localparam int STEP_W  = 7;

  localparam logic [FREQ_W-1:0] FREQ_SCALE = 22'd4096000;

  localparam logic [14:0] LOW_FREQ_RST   = 15'd12544;
  localparam logic [14:0] RATE_THR_RST   = 15'd2560;
  localparam logic [15:0] UNSTABLE_RST   = 16'd500;
  localparam logic [15:0] STABLE_RST     = 16'd500;

  localparam logic [STEP_W-1:0] FDIV_STEPS = 7'd22;
  localparam logic [STEP_W-1:0] RDIV_STEPS = 7'd67;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_SWITCH = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_MAINT  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_LOW_FREQ = 2'd0,
    REG_RATE     = 2'd1,
    REG_UNSTABLE = 2'd2,
    REG_STABLE   = 2'd3
  } cfg_reg_t;

endpackage

// File: sv/flsc_div.sv
// Restoring divider, one quotient bit per cycle.
module flsc_div import flsc_pkg::*; #(
  parameter int DW = 67,
  parameter int VW = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DW-1:0]     dividend,
  input  logic [VW-1:0]     divisor,
  input  logic [STEP_W-1:0] steps,
  output logic              done,
  output logic [DW-1:0]     quotient
);

  logic [VW-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]     quo_r, quo_nxt;
  logic [VW-1:0]     dvs_r;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [VW:0]       trial, diff;

  assign trial = {rem_r, quo_r[DW-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // subtract where it fits, shift the quotient bit in
      if (!diff[VW]) begin
        rem_nxt = diff[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: sv/flsc_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
module flsc_mul import flsc_pkg::*; #(
  parameter int AW = 44,
  parameter int BW = 22
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    op_a,
  input  logic [BW-1:0]    op_b,
  output logic             done,
  output logic [AW+BW-1:0] product
);

  localparam int PW = AW + BW;

  logic [PW-1:0]     acc_r, acc_nxt, mcand_r, mcand_nxt;
  logic [BW-1:0]     mplier_r, mplier_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (start) begin
      acc_nxt    = '0;
      mcand_nxt  = PW'(op_a);
      mplier_nxt = op_b;
      cnt_nxt    = STEP_W'(BW);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt  = {mcand_r[PW-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[BW-1:1]};
      cnt_nxt    = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// File: sv/frequency_load_shedding_controller.sv
// Top level of the under-frequency load shedding controller.
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_ready    cmd, period_count, switches
//  out_     output     out_valid / out_ready  load_on, shed_loads, shedding, managing,
//                                             frequency, rate_of_change
//  cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time.
// Switch, tick and maintenance items pass through accept, apply and load.
// A frequency sample passes through accept, the period division, prepare, two
// passes of the bit-serial multiplier, the rate division, apply and load; a zero
// count skips the period division.
// Reset is synchronous, active low, and clears all control state at once.
// A result held on a stalled output blocks the next item only at its own finish.
module frequency_load_shedding_controller import flsc_pkg::*; #(
  parameter int NUM_LOADS   = 5,
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [15:0]        in_period_count,
  input  logic [4:0]         in_switches,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_load_on,
  output logic [4:0]         out_shed_loads,
  output logic               out_shedding,
  output logic               out_managing,
  output logic [21:0]        out_frequency,
  output logic signed [31:0] out_rate_of_change,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_FDIV, S_PREP, S_MUL1, S_MUL2, S_RDIV, S_APPLY, S_RESP
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [14:0] low_thr_r, rate_thr_r;
  logic [15:0] unst_dly_r, stab_dly_r;

  // relay state
  logic [NUM_LOADS-1:0] status_r, status_nxt, snap_r, snap_nxt;
  logic                 shed_r, shed_nxt, manage_r, manage_nxt;
  logic [FREQ_W-1:0]    prev_f_r, prev_f_nxt, f_r, f_nxt;
  logic [31:0]          rate_r, rate_nxt, qs_r, qs_nxt;
  logic [31:0]          time_r, time_nxt, ut0_r, ut0_nxt, st0_r, st0_nxt;
  logic                 urun_r, urun_nxt, srun_r, srun_nxt;
  logic                 neg_r, neg_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [NUM_LOADS-1:0] sw_r, sw_nxt;

  logic              out_valid_r;
  logic [4:0]        out_load_r, out_shedl_r;
  logic              out_shed_r, out_man_r;
  logic [21:0]       out_freq_r;
  logic [31:0]       out_rate_r;

  // serial units
  logic              div_start, div_done, mul_start, mul_done;
  logic [DVD_W-1:0]  div_dvd, div_q;
  logic [DVS_W-1:0]  div_dvs;
  logic [STEP_W-1:0] div_steps;
  logic [MULA_W-1:0] mul_a;
  logic [MULB_W-1:0] mul_b;
  logic [MULA_W+MULB_W-1:0] mul_p;

  logic [COUNT_WIDTH-1:0] count;
  logic [SUM_W-1:0]       sum;
  logic [FREQ_W-1:0]      mag;
  logic                   in_acc;

  flsc_div #(.DW(DVD_W), .VW(DVS_W)) u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_dvd), .divisor(div_dvs),
    .steps(div_steps), .done(div_done), .quotient(div_q)
  );

  flsc_mul #(.AW(MULA_W), .BW(MULB_W)) u_mul (
    .clk, .rst_n, .start(mul_start), .op_a(mul_a), .op_b(mul_b),
    .done(mul_done), .product(mul_p)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign count     = COUNT_WIDTH'(in_period_count);
  assign sum       = {1'b0, f_r} + {1'b0, prev_f_r};
  assign mag       = (prev_f_r > f_r) ? (prev_f_r - f_r) : (f_r - prev_f_r);

  // operand selection for the shared units
  always_comb begin
    div_start = 1'b0;
    div_dvd   = {FREQ_SCALE, (DVD_W-FREQ_W)'(0)};
    div_dvs   = DVS_W'(count);
    div_steps = FDIV_STEPS;
    mul_start = 1'b0;
    mul_a     = MULA_W'(mag);
    mul_b     = f_r;
    if (state_r == S_IDLE) begin
      div_start = in_acc && (cmd_t'(in_cmd) == CMD_SAMPLE) && (count != '0);
    end else if (state_r == S_PREP) begin
      mul_start = (sum != '0);
    end else if (state_r == S_MUL1) begin
      mul_start = mul_done;
      mul_a     = mul_p[MULA_W-1:0];
      mul_b     = prev_f_r;
    end else if (state_r == S_MUL2) begin
      div_start = mul_done;
      div_dvd   = {mul_p, 1'b0};
      div_dvs   = {1'b0, sum, 8'd0};
      div_steps = RDIV_STEPS;
    end
  end

  // sequencing and relay logic
  always_comb begin
    logic [NUM_LOADS-1:0] cand, pick;
    logic                 found, unstable;
    logic [31:0]          qv;
    state_nxt  = state_r;
    status_nxt = status_r;
    snap_nxt   = snap_r;
    shed_nxt   = shed_r;
    manage_nxt = manage_r;
    prev_f_nxt = prev_f_r;
    f_nxt      = f_r;
    rate_nxt   = rate_r;
    qs_nxt     = qs_r;
    neg_nxt    = neg_r;
    time_nxt   = time_r;
    ut0_nxt    = ut0_r;
    st0_nxt    = st0_r;
    urun_nxt   = urun_r;
    srun_nxt   = srun_r;
    cmd_nxt    = cmd_r;
    sw_nxt     = sw_r;
    cand       = '0;
    pick       = '0;
    found      = 1'b0;
    unstable   = 1'b0;
    qv         = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt = cmd_t'(in_cmd);
          sw_nxt  = NUM_LOADS'(in_switches);
          if (cmd_t'(in_cmd) != CMD_SAMPLE) begin
            state_nxt = S_APPLY;
          end else if (count == '0) begin
            f_nxt     = FREQ_SCALE;
            state_nxt = S_PREP;
          end else begin
            state_nxt = S_FDIV;
          end
        end
      end
      S_FDIV: begin
        if (div_done) begin
          f_nxt     = div_q[FREQ_W-1:0];
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        neg_nxt = prev_f_r > f_r;
        if (sum == '0) begin
          qs_nxt    = '0;
          state_nxt = S_APPLY;
        end else begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        if (mul_done) state_nxt = S_MUL2;
      end
      S_MUL2: begin
        if (mul_done) state_nxt = S_RDIV;
      end
      S_RDIV: begin
        if (div_done) begin
          // saturate the magnitude: 2^31 for a fall, 2^31-1 for a rise
          if (|div_q[DVD_W-1:31]) qs_nxt = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
          else                    qs_nxt = div_q[31:0];
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        case (cmd_r)
          CMD_SAMPLE: begin
            qv         = qs_r;
            rate_nxt   = neg_r ? (32'd0 - qv) : qv;
            prev_f_nxt = f_r;
            if (manage_r) begin
              unstable = (f_r < FREQ_W'(low_thr_r)) || (qv > 32'(rate_thr_r));
              if (unstable) begin
                if (!shed_r) begin
                  snap_nxt   = status_r;
                  shed_nxt   = 1'b1;
                  status_nxt = status_r & (status_r - 1'b1);
                end
                srun_nxt = 1'b0;
                if (!urun_r) begin
                  urun_nxt = 1'b1;
                  ut0_nxt  = time_r;
                end
              end else begin
                if (!srun_r) begin
                  srun_nxt = 1'b1;
                  st0_nxt  = time_r;
                end
                urun_nxt = 1'b0;
              end
              // further shed after continued instability
              if (urun_nxt && (time_r - ut0_nxt) >= 32'(unst_dly_r)) begin
                status_nxt = status_nxt & (status_nxt - 1'b1);
                urun_nxt   = 1'b0;
              end
              // restore the highest snapshotted load after continued stability
              if (srun_nxt && (time_r - st0_nxt) >= 32'(stab_dly_r)) begin
                srun_nxt = 1'b0;
                if (shed_nxt) begin
                  cand = snap_nxt & ~status_nxt;
                  for (int i = NUM_LOADS - 1; i >= 0; i--) begin
                    if (!found && cand[i]) begin
                      pick[i] = 1'b1;
                      found   = 1'b1;
                    end
                  end
                  status_nxt = status_nxt | pick;
                  if (status_nxt == snap_nxt) shed_nxt = 1'b0;
                end
              end
            end
          end
          CMD_SWITCH: begin
            if (shed_r) begin
              status_nxt = status_r & sw_r;
              snap_nxt   = snap_r & sw_r;
            end else begin
              status_nxt = sw_r;
            end
          end
          CMD_TICK: time_nxt = time_r + 32'd1;
          default: begin
            shed_nxt   = 1'b0;
            manage_nxt = !manage_r;
          end
        endcase
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      low_thr_r   <= LOW_FREQ_RST;
      rate_thr_r  <= RATE_THR_RST;
      unst_dly_r  <= UNSTABLE_RST;
      stab_dly_r  <= STABLE_RST;
      status_r    <= '0;
      snap_r      <= '0;
      shed_r      <= 1'b0;
      manage_r    <= 1'b0;
      prev_f_r    <= '0;
      rate_r      <= '0;
      time_r      <= '0;
      ut0_r       <= '0;
      st0_r       <= '0;
      urun_r      <= 1'b0;
      srun_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      snap_r   <= snap_nxt;
      shed_r   <= shed_nxt;
      manage_r <= manage_nxt;
      prev_f_r <= prev_f_nxt;
      rate_r   <= rate_nxt;
      time_r   <= time_nxt;
      ut0_r    <= ut0_nxt;
      st0_r    <= st0_nxt;
      urun_r   <= urun_nxt;
      srun_r   <= srun_nxt;
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_LOW_FREQ: low_thr_r  <= cfg_data[14:0];
          REG_RATE:     rate_thr_r <= cfg_data[14:0];
          REG_UNSTABLE: unst_dly_r <= cfg_data;
          default:      stab_dly_r <= cfg_data;
        endcase
      end
      // drop the result once transferred, load a new one when the slot is free
      if (state_r == S_RESP && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    f_r     <= f_nxt;
    qs_r    <= qs_nxt;
    neg_r   <= neg_nxt;
    cmd_r   <= cmd_nxt;
    sw_r    <= sw_nxt;
    if (state_r == S_RESP && (!out_valid_r || out_ready)) begin
      out_load_r  <= 5'(status_r);
      out_shedl_r <= shed_r ? 5'(snap_r & ~status_r) : 5'd0;
      out_shed_r  <= shed_r;
      out_man_r   <= manage_r;
      out_freq_r  <= prev_f_r;
      out_rate_r  <= rate_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_load_on        = out_load_r;
  assign out_shed_loads     = out_shedl_r;
  assign out_shedding       = out_shed_r;
  assign out_managing       = out_man_r;
  assign out_frequency      = out_freq_r;
  assign out_rate_of_change = out_rate_r;

endmodule

// File: tb/sv/frequency_load_shedding_controller_tb.sv
// Testbench for the frequency load shedding controller: directed and random commands.
`timescale 1ns / 1ps

module frequency_load_shedding_controller_tb import flsc_pkg::*;;

  // Result of one command as seen on the output channel
  typedef struct packed {
    logic [4:0]         load_on;
    logic [4:0]         shed_loads;
    logic               shedding;
    logic               managing;
    logic [21:0]        frequency;
    logic signed [31:0] rate;
  } relay_state_t;

  // Behavioural model of the relay plus the queue of outstanding results
  class relay_scoreboard;
    logic [14:0] low_thr, rate_thr;
    logic [15:0] unstable_dly, stable_dly;
    logic [4:0]  loads, snap;
    bit          shedding, managing;
    logic [21:0] prev_f;
    logic [31:0] rate, now_ms, unstable_t0, stable_t0;
    bit          unstable_on, stable_on;
    relay_state_t pending[$];
    int          errors;

    function new();
      low_thr = LOW_FREQ_RST; rate_thr = RATE_THR_RST;
      unstable_dly = UNSTABLE_RST; stable_dly = STABLE_RST;
      loads = '0; snap = '0; shedding = 0; managing = 0;
      prev_f = '0; rate = '0; now_ms = '0; unstable_t0 = '0; stable_t0 = '0;
      unstable_on = 0; stable_on = 0; errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [15:0] d);
      case (idx)
        REG_LOW_FREQ: low_thr = d[14:0];
        REG_RATE:     rate_thr = d[14:0];
        REG_UNSTABLE: unstable_dly = d;
        default:      stable_dly = d;
      endcase
    endfunction

    // Exact truncated rate, saturated to 32 bits signed
    function logic [31:0] rate_calc(logic [63:0] f, logic [63:0] fp);
      logic [127:0] num, q;
      logic [63:0] s, mag;
      bit neg;
      s = f + fp;
      if (s == 0) return 32'd0;
      neg = fp > f;
      mag = neg ? fp - f : f - fp;
      num = 128'(2) * f * fp * mag;
      q = num / (128'(s) * 256);
      if (neg) begin
        if (q > 128'h8000_0000) q = 128'h8000_0000;
        return 32'(-q);
      end
      if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
      return q[31:0];
    endfunction

    function void drop_lowest();
      for (int i = 0; i < 5; i++)
        if (loads[i]) begin
          loads[i] = 1'b0;
          return;
        end
    endfunction

    function void bring_back_highest();
      if (!shedding) return;
      for (int i = 4; i >= 0; i--)
        if (!loads[i] && snap[i]) begin
          loads[i] = 1'b1;
          break;
        end
      if (loads == snap) shedding = 0;
    endfunction

    function void take_sample(logic [15:0] cnt);
      logic [21:0] f;
      logic [31:0] mag;
      f = (cnt == 0) ? FREQ_SCALE : 22'(32'd4096000 / cnt);
      rate = rate_calc(64'(f), 64'(prev_f));
      prev_f = f;
      if (!managing) return;
      mag = rate[31] ? -rate : rate;
      if (f < low_thr || mag > rate_thr) begin
        if (!shedding) begin
          snap = loads; shedding = 1; drop_lowest();
        end
        stable_on = 0;
        if (!unstable_on) begin
          unstable_on = 1; unstable_t0 = now_ms;
        end
      end else begin
        if (!stable_on) begin
          stable_on = 1; stable_t0 = now_ms;
        end
        unstable_on = 0;
      end
      if (unstable_on && (now_ms - unstable_t0) >= unstable_dly) begin
        drop_lowest(); unstable_on = 0;
      end
      if (stable_on && (now_ms - stable_t0) >= stable_dly) begin
        bring_back_highest(); stable_on = 0;
      end
    endfunction

    // Note an accepted command and queue the state it should leave
    function void note_command(cmd_t c, logic [15:0] cnt, logic [4:0] sw);
      relay_state_t r;
      case (c)
        CMD_SAMPLE: take_sample(cnt);
        CMD_SWITCH: begin
          if (shedding) begin
            loads &= sw; snap &= sw;
          end else loads = sw;
        end
        CMD_TICK: now_ms = now_ms + 1;
        default: begin
          shedding = 0; managing = !managing;
        end
      endcase
      r.load_on = loads;
      r.shed_loads = shedding ? (snap & ~loads) : 5'd0;
      r.shedding = shedding;
      r.managing = managing;
      r.frequency = prev_f;
      r.rate = rate;
      pending.push_back(r);
    endfunction

    function void check_result(relay_state_t got);
      relay_state_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.load_on !== e.load_on) begin
        $error("load_on exp %0h got %0h", e.load_on, got.load_on); errors++;
      end
      if (got.shed_loads !== e.shed_loads) begin
        $error("shed_loads exp %0h got %0h", e.shed_loads, got.shed_loads); errors++;
      end
      if (got.shedding !== e.shedding) begin
        $error("shedding exp %0b got %0b", e.shedding, got.shedding); errors++;
      end
      if (got.managing !== e.managing) begin
        $error("managing exp %0b got %0b", e.managing, got.managing); errors++;
      end
      if (got.frequency !== e.frequency) begin
        $error("frequency exp %0d got %0d", e.frequency, got.frequency); errors++;
      end
      if (got.rate !== e.rate) begin
        $error("rate_of_change exp %0d got %0d", e.rate, got.rate); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic [1:0] in_cmd = '0;
  logic [15:0] in_period_count = '0;
  logic [4:0] in_switches = '0;
  logic out_valid, out_ready = 1'b0;
  logic [4:0] out_load_on, out_shed_loads;
  logic out_shedding, out_managing;
  logic [21:0] out_frequency;
  logic signed [31:0] out_rate_of_change;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  relay_scoreboard sb = new();
  int stall_hold = 0;   // cycles for the receiver to hold off, set by stimulus
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frequency_load_shedding_controller u_dut (.*);

  // Receiver: stall on its own rhythm; a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (stall_hold > 0) begin
      out_ready <= 1'b0;
      stall_hold <= stall_hold - 1;
    end else if ((($urandom & 63) < 24)) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // Check each result transfer; watchdog counts quiet cycles
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_load_on, out_shed_loads, out_shedding, out_managing,
                       out_frequency, out_rate_of_change});
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("FAIL frequency_load_shedding_controller");
      $finish;
    end
  end

  // Offer one command, hold it until transferred, note it
  task automatic send_cmd(cmd_t c, logic [15:0] cnt, logic [4:0] sw);
    in_valid <= 1'b1;
    in_cmd <= c;
    in_period_count <= cnt;
    in_switches <= sw;
    do @(posedge clk); while (!in_ready);
    sb.note_command(c, cnt, sw);
  endtask

  // Lower valid after a burst and idle for a while
  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Registers are to change only while the block is idle; neither this task nor the block enforces it
  task automatic write_reg(cfg_reg_t idx, logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic ticks(int n);
    repeat (n) send_cmd(CMD_TICK, 16'($urandom), 5'($urandom));
  endtask

  // Random command, biased towards samples near the threshold region
  task automatic random_cmd();
    int pick;
    logic [15:0] cnt;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      case ($urandom_range(0, 5))
        0: cnt = 16'($urandom);
        1: cnt = 16'($urandom_range(0, 3));
        default: cnt = 16'($urandom_range(300, 360));   // roughly 44..53 Hz
      endcase
      send_cmd(CMD_SAMPLE, cnt, 5'($urandom));
    end else if (pick < 60) send_cmd(CMD_SWITCH, 16'($urandom), 5'($urandom));
    else if (pick < 97) send_cmd(CMD_TICK, 16'($urandom), 5'($urandom));
    else send_cmd(CMD_MAINT, 16'($urandom), 5'($urandom));
  endtask

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && n > 0) begin
        random_cmd();
        burst--; n--;
      end
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 150));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of counts, every command, shed and restore paths
    send_cmd(CMD_SAMPLE, 16'd0, 5'd0);        // zero count saturates
    send_cmd(CMD_SAMPLE, 16'hFFFF, 5'h1F);    // steep negative rate
    send_cmd(CMD_SAMPLE, 16'd1, 5'd0);
    send_cmd(CMD_SWITCH, 16'd0, 5'h1F);
    send_cmd(CMD_MAINT, 16'd0, 5'd0);         // enable management
    send_cmd(CMD_SAMPLE, 16'd320, 5'd0);      // 50 Hz after a jump: unstable
    ticks(3);
    send_cmd(CMD_SWITCH, 16'd0, 5'b10111);    // switch change while shedding
    send_cmd(CMD_SAMPLE, 16'd320, 5'd0);
    send_cmd(CMD_SAMPLE, 16'd400, 5'd0);      // low frequency
    send_cmd(CMD_MAINT, 16'd0, 5'd0);
    send_cmd(CMD_SAMPLE, 16'd2, 5'd0);        // not managing: value only
    send_cmd(CMD_MAINT, 16'd0, 5'd0);
    drain();

    // Zero delays: timers expire on the sample that starts them
    write_reg(REG_UNSTABLE, 16'd0);
    write_reg(REG_STABLE, 16'd0);
    send_cmd(CMD_SWITCH, 16'd0, 5'h1F);
    send_cmd(CMD_SAMPLE, 16'd120, 5'd0);
    send_cmd(CMD_SAMPLE, 16'd120, 5'd0);
    send_cmd(CMD_SAMPLE, 16'd80, 5'd0);
    send_cmd(CMD_SAMPLE, 16'd80, 5'd0);
    send_cmd(CMD_SAMPLE, 16'd80, 5'd0);
    drain();

    // Phases of random traffic across several register settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_LOW_FREQ, 16'd12544); write_reg(REG_RATE, 16'd2560);
          write_reg(REG_UNSTABLE, 16'd5); write_reg(REG_STABLE, 16'd8);
        end
        1: begin
          write_reg(REG_LOW_FREQ, 16'd0); write_reg(REG_RATE, 16'd0);
          write_reg(REG_UNSTABLE, 16'd1); write_reg(REG_STABLE, 16'd0);
        end
        2: begin
          write_reg(REG_LOW_FREQ, 16'h7FFF); write_reg(REG_RATE, 16'h7FFF);
          write_reg(REG_UNSTABLE, 16'hFFFF); write_reg(REG_STABLE, 16'd2);
        end
        3: begin
          write_reg(REG_LOW_FREQ, 16'd25599); write_reg(REG_RATE, 16'd25599);
          write_reg(REG_UNSTABLE, 16'd3); write_reg(REG_STABLE, 16'hFFFF);
        end
        default: begin
          write_reg(REG_LOW_FREQ, 16'($urandom_range(11000, 14000)));
          write_reg(REG_RATE, 16'($urandom_range(0, 25599)));
          write_reg(REG_UNSTABLE, 16'($urandom_range(0, 6)));
          write_reg(REG_STABLE, 16'($urandom_range(0, 6)));
        end
      endcase
      if (ph == 1) begin
        // Hold the receiver off while the sender keeps offering items
        stall_hold <= 1500;
        random_phase(20);
      end
      random_phase(90);
      drain();   // sender pauses until every result is back
    end

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASS frequency_load_shedding_controller");
    else
      $display("FAIL frequency_load_shedding_controller");
    $finish;
  end

endmodule

// File: sim.f
sv/flsc_pkg.sv
sv/flsc_div.sv
sv/flsc_mul.sv
sv/frequency_load_shedding_controller.sv
tb/sv/frequency_load_shedding_controller_tb.sv
